/* design/kdlp_pkg.sv */
// Shared types, constants and codes for the key debounce and long-press unit.
package kdlp_pkg;

    // Widths and counts
    localparam int TICK_BITS  = 32;
    localparam int NUM_KEYS   = 2;
    localparam int CFG_W      = 16;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // Register indexes (paddr[2])
    localparam logic [0:0] REG_DEBOUNCE = 1'd0;
    localparam logic [0:0] REG_LONG     = 1'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd20;
    localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;

    // Per-key phase
    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_LONG     = 2'd3
    } phase_t;

    // Event codes
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_SHORT     = 3'd1,
        EV_LONG      = 3'd2,
        EV_LONG_HELD = 3'd3,
        EV_RELEASE   = 3'd4
    } event_t;

    // Input word
    typedef struct packed {
        logic [TICK_BITS-1:0] now_tick;
        logic                 key_a_down;
        logic                 key_b_down;
        logic                 clear_a;
        logic                 clear_b;
    } kdlp_in_t;

    // Output word
    typedef struct packed {
        logic [2:0] event_a;
        logic [2:0] event_b;
        logic       held_a;
        logic       held_b;
    } kdlp_out_t;

    // What one lane reports for the word being accepted
    typedef struct packed {
        event_t key_event;
        logic   held;
    } kdlp_lane_res_t;

endpackage

/* design/kdlp_lane.sv */
// One key lane: phase machine, start tick, sticky event and long-fired flag.
module kdlp_lane
    import kdlp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 down,
    input  logic                 clr,
    input  logic [TICK_BITS-1:0] now_tick,
    input  logic [CFG_W-1:0]     debounce_ticks,
    input  logic [CFG_W-1:0]     long_press_ticks,
    output kdlp_lane_res_t       res
);

    phase_t               phase_reg, phase_next;
    logic [TICK_BITS-1:0] start_tick_reg, start_tick_next;
    event_t               event_reg, event_next;
    logic                 long_fired_reg, long_fired_next;
    logic [TICK_BITS-1:0] elapsed;
    logic                 db_done;
    logic                 long_done;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            start_tick_reg <= '0;
            event_reg      <= EV_NONE;
            long_fired_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            start_tick_reg <= start_tick_next;
            event_reg      <= event_next;
            long_fired_reg <= long_fired_next;
        end
    end

    // Elapsed time wraps with the tick counter
    assign elapsed   = now_tick - start_tick_reg;
    assign db_done   = elapsed >= TICK_BITS'(debounce_ticks);
    assign long_done = elapsed > TICK_BITS'(long_press_ticks);

    // Next state; clear acts before the scan
    always_comb
    begin
        phase_next      = phase_reg;
        start_tick_next = start_tick_reg;
        event_next      = clr ? EV_NONE : event_reg;
        long_fired_next = long_fired_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (down)
                begin
                    phase_next      = PH_DEBOUNCE;
                    start_tick_next = now_tick;
                end
            end
            PH_DEBOUNCE:
            begin
                if (db_done)
                begin
                    if (down)
                    begin
                        phase_next      = PH_PRESSED;
                        start_tick_next = now_tick;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_PRESSED:
            begin
                if (down)
                begin
                    if (long_done)
                    begin
                        phase_next      = PH_LONG;
                        event_next      = EV_LONG;
                        long_fired_next = 1'b1;
                    end
                end
                else
                begin
                    if (!long_fired_reg)
                    begin
                        event_next = EV_SHORT;
                    end
                    phase_next      = PH_IDLE;
                    long_fired_next = 1'b0;
                end
            end
            PH_LONG:
            begin
                if (down)
                begin
                    event_next = EV_LONG_HELD;
                end
                else
                begin
                    event_next      = EV_RELEASE;
                    phase_next      = PH_IDLE;
                    long_fired_next = 1'b0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Result for the word being accepted
    assign res.key_event = event_next;
    assign res.held      = (phase_next == PH_PRESSED) || (phase_next == PH_LONG);

    // Long-fired flag tracks the long-press phase exactly
    a_long_flag: assert property (@(posedge clk) disable iff (!rst_n)
        long_fired_reg == (phase_reg == PH_LONG))
        else $error("long_fired out of step with phase");

    // No word, no change of state
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(event_reg) && $stable(start_tick_reg))
        else $error("lane state changed without a word");

    // A press seen while idle starts debouncing from that tick
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        step && down && (phase_reg == PH_IDLE) |=>
            (phase_reg == PH_DEBOUNCE) && (start_tick_reg == $past(now_tick)))
        else $error("press not taken into debounce");

endmodule

/* design/kdlp_merge.sv */
// Merge of the lane results into the output word, with a two-entry output buffer.
module kdlp_merge
    import kdlp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  kdlp_lane_res_t lane_res [NUM_KEYS],
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output kdlp_out_t      out_data
);

    kdlp_out_t  word;
    kdlp_out_t  slot0_reg, slot0_next;
    kdlp_out_t  slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    // Gather the lanes into one word
    always_comb
    begin
        word.event_a = lane_res[0].key_event;
        word.event_b = lane_res[1].key_event;
        word.held_a  = lane_res[0].held;
        word.held_b  = lane_res[1].held;
    end

    assign pop       = out_valid && out_ready;
    assign room      = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;

    // Buffer update; slot 0 is the head
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        count_next = count_reg;
        case ({push, pop})
            2'b10:
            begin
                if (count_reg == 2'd0)
                begin
                    slot0_next = word;
                end
                else
                begin
                    slot1_next = word;
                end
                count_next = count_reg + 2'd1;
            end
            2'b01:
            begin
                slot0_next = slot1_reg;
                count_next = count_reg - 2'd1;
            end
            2'b11:
            begin
                if (count_reg == 2'd1)
                begin
                    slot0_next = word;
                end
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = word;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Count under reset; payload slots need none
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // Occupancy never passes two
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("output buffer overfilled");

    // A word is only written when there is room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> room)
        else $error("word pushed into full buffer");

    // A word pushed into an empty buffer is presented next cycle
    a_pass: assert property (@(posedge clk) disable iff (!rst_n)
        push && (count_reg == 2'd0) |=> out_valid && (out_data == $past(word)))
        else $error("word lost in output buffer");

endmodule

/* design/key_debounce_long_press_unit.sv */
// Top level of the key debounce and long-press unit: config registers, lanes, merge.
//
// Usage:
//   Each input word (in_valid/in_ready, in_data) is one scan: the current tick,
//   the level of each key and per-key clear requests for the sticky events.
//   Each accepted word yields exactly one output word (out_valid/out_ready,
//   out_data) with each key's sticky event and whether it is held.
//   One lane per key updates its phase machine in the cycle the word is
//   accepted; the result goes into the output buffer, whose head drives out_data.
//   Throughput is one word per clock: the lanes hold one subtract and two
//   compares each, and the two-entry output buffer lets scans continue while
//   a result waits. If the receiver stalls, in_ready drops only once two
//   results are waiting.
//   debounce_ticks (address 0) and long_press_ticks (address 4) are written via APB,
//   low 16 bits of pwdata; the user must write them only while no word is in flight
//   (not enforced here); pready is always high and reads return the register value.
//   Reset (rst_n low, asynchronous) sets every key idle, clears events and
//   the output buffer, and loads debounce_ticks 20, long_press_ticks 1000.
module key_debounce_long_press_unit
    import kdlp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  kdlp_in_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output kdlp_out_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] debounce_reg;
    logic [CFG_W-1:0] long_reg;
    logic             cfg_wr;
    logic [0:0]       reg_idx;
    logic             step;
    logic             room;
    logic             down [NUM_KEYS];
    logic             clr  [NUM_KEYS];
    kdlp_lane_res_t   lane_res [NUM_KEYS];

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            long_reg     <= LONG_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_DEBOUNCE: debounce_reg <= pwdata[CFG_W-1:0];
                REG_LONG:     long_reg     <= pwdata[CFG_W-1:0];
                default:      debounce_reg <= debounce_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (reg_idx)
            REG_DEBOUNCE: prdata = APB_DATA_W'(debounce_reg);
            REG_LONG:     prdata = APB_DATA_W'(long_reg);
            default:      prdata = '0;
        endcase
    end

    // Handshake and per-key inputs
    assign in_ready = room;
    assign step     = in_valid && in_ready;

    assign down[0] = in_data.key_a_down;
    assign down[1] = in_data.key_b_down;
    assign clr[0]  = in_data.clear_a;
    assign clr[1]  = in_data.clear_b;

    // One lane per key
    for (genvar k = 0; k < NUM_KEYS; k++)
    begin : g_lane
        kdlp_lane u_lane (
            .clk              (clk),
            .rst_n            (rst_n),
            .step             (step),
            .down             (down[k]),
            .clr              (clr[k]),
            .now_tick         (in_data.now_tick),
            .debounce_ticks   (debounce_reg),
            .long_press_ticks (long_reg),
            .res              (lane_res[k])
        );
    end

    // Merge and output buffer
    kdlp_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .lane_res  (lane_res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the key debounce and long-press unit.
module testbench;
    import kdlp_pkg::*;

    // Cycles with no accepted word or APB transfer before the run is abandoned
    localparam int STALL_LIMIT = 2000;

    // Expected-word store and key-state predictor
    class key_scoreboard;
        phase_t               key_phase [NUM_KEYS];
        logic [TICK_BITS-1:0] key_start [NUM_KEYS];
        event_t               key_event [NUM_KEYS];
        bit                   key_long  [NUM_KEYS];
        logic [CFG_W-1:0]     debounce_ticks;
        logic [CFG_W-1:0]     long_ticks;
        kdlp_out_t            expected_words [$];
        int                   errors;

        function new();
            debounce_ticks = DEBOUNCE_RST;
            long_ticks     = LONG_RST;
            errors         = 0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                key_phase[k] = PH_IDLE;
                key_start[k] = '0;
                key_event[k] = EV_NONE;
                key_long[k]  = 1'b0;
            end
        endfunction

        function void report(string msg);
            errors++;
            // keep the log short if the design is badly broken
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $time, msg);
        endfunction

        function void set_reg(logic [0:0] idx, logic [CFG_W-1:0] v);
            if (idx == REG_DEBOUNCE)
                debounce_ticks = v;
            else
                long_ticks = v;
        endfunction

        // One key's phase machine for one scan; elapsed wraps with the tick
        function void step_key(int k, logic down, logic [TICK_BITS-1:0] now);
            logic [TICK_BITS-1:0] elapsed;
            elapsed = now - key_start[k];
            case (key_phase[k])
                PH_IDLE:
                begin
                    if (down)
                    begin
                        key_phase[k] = PH_DEBOUNCE;
                        key_start[k] = now;
                    end
                end
                PH_DEBOUNCE:
                begin
                    // levels before the threshold do not matter
                    if (elapsed >= debounce_ticks)
                    begin
                        if (down)
                        begin
                            key_phase[k] = PH_PRESSED;
                            key_start[k] = now;
                        end
                        else
                            key_phase[k] = PH_IDLE;
                    end
                end
                PH_PRESSED:
                begin
                    if (down)
                    begin
                        if (elapsed > long_ticks)
                        begin
                            key_phase[k] = PH_LONG;
                            key_event[k] = EV_LONG;
                            key_long[k]  = 1'b1;
                        end
                    end
                    else
                    begin
                        if (!key_long[k])
                            key_event[k] = EV_SHORT;
                        key_phase[k] = PH_IDLE;
                        key_long[k]  = 1'b0;
                    end
                end
                default:
                begin
                    if (down)
                        key_event[k] = EV_LONG_HELD;
                    else
                    begin
                        key_event[k] = EV_RELEASE;
                        key_phase[k] = PH_IDLE;
                        key_long[k]  = 1'b0;
                    end
                end
            endcase
        endfunction

        // Accepted scan word: clears first, then both keys, then queue the result
        function void note_scan(kdlp_in_t w);
            kdlp_out_t want;
            if (w.clear_a)
                key_event[0] = EV_NONE;
            if (w.clear_b)
                key_event[1] = EV_NONE;
            step_key(0, w.key_a_down, w.now_tick);
            step_key(1, w.key_b_down, w.now_tick);
            want.event_a = key_event[0];
            want.event_b = key_event[1];
            want.held_a  = (key_phase[0] == PH_PRESSED) || (key_phase[0] == PH_LONG);
            want.held_b  = (key_phase[1] == PH_PRESSED) || (key_phase[1] == PH_LONG);
            expected_words.push_back(want);
        endfunction

        // Accepted output word against the oldest expectation
        function void check_word(kdlp_out_t got);
            kdlp_out_t want;
            if (expected_words.size() == 0)
            begin
                report($sformatf("output word %h with nothing expected", got));
                return;
            end
            want = expected_words.pop_front();
            if (got.event_a !== want.event_a)
                report($sformatf("event_a got %0d want %0d", got.event_a, want.event_a));
            if (got.event_b !== want.event_b)
                report($sformatf("event_b got %0d want %0d", got.event_b, want.event_b));
            if (got.held_a !== want.held_a)
                report($sformatf("held_a got %b want %b", got.held_a, want.held_a));
            if (got.held_b !== want.held_b)
                report($sformatf("held_b got %b want %b", got.held_b, want.held_b));
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    kdlp_in_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    kdlp_out_t             out_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    key_scoreboard         sb;
    bit                    calm = 1'b0;
    logic [TICK_BITS-1:0]  scan_tick;
    logic                  level [NUM_KEYS];
    int                    run_left [NUM_KEYS];
    int                    stall_cycles = 0;

    key_debounce_long_press_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #6 clk = ~clk;

    // Monitor: note accepted scans before checking results, plus the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_scan(in_data);
            if (out_valid && out_ready)
                sb.check_word(out_data);
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("key_debounce_long_press_unit verification failed");
            $finish;
        end
    end

    // Receiver: bursts of back-pressure, none once the run goes calm
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(0, 24)) @(posedge clk);
        end
    end

    // Offer one scan word and hold it until taken
    task send_scan(kdlp_in_t w);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task scan(logic [TICK_BITS-1:0] t, logic a, logic b, logic ca, logic cb);
        kdlp_in_t w;
        w.now_tick   = t;
        w.key_a_down = a;
        w.key_b_down = b;
        w.clear_a    = ca;
        w.clear_b    = cb;
        send_scan(w);
    endtask

    // Stop sending until every expected word has come back
    task drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // APB write of one register, then read it back
    task set_reg(logic [0:0] idx, logic [CFG_W-1:0] v);
        logic [APB_DATA_W-1:0] wdata;
        wdata            = $urandom;
        wdata[CFG_W-1:0] = v;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_reg(idx, v);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata[CFG_W-1:0] !== v)
            sb.report($sformatf("register %0d reads %h, wrote %h", idx, prdata, v));
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // New thresholds, only with nothing in flight
    task retune(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lng);
        drain();
        repeat (2) @(posedge clk);
        set_reg(REG_DEBOUNCE, deb);
        set_reg(REG_LONG, lng);
    endtask

    // Mostly a rising tick with held key levels, some bounce and some tick jumps
    task random_phase(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] lng, int n);
        int       span;
        kdlp_in_t w;
        span = (int'(deb) + int'(lng)) / 6 + 3;
        retune(deb, lng);
        for (int i = 0; i < n; i++)
        begin
            if (i == n / 2 && $urandom_range(0, 1) == 1)
                drain();
            if ($urandom_range(0, 9) == 0)
                scan_tick = $urandom;
            else
                scan_tick = scan_tick + $urandom_range(0, span);
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (run_left[k] == 0)
                begin
                    level[k]    = ~level[k];
                    run_left[k] = $urandom_range(1, 24);
                end
                run_left[k]--;
            end
            w.now_tick   = scan_tick;
            w.key_a_down = level[0] ^ ($urandom_range(0, 11) == 0);
            w.key_b_down = level[1] ^ ($urandom_range(0, 11) == 0);
            w.clear_a    = ($urandom_range(0, 5) == 0);
            w.clear_b    = ($urandom_range(0, 5) == 0);
            send_scan(w);
        end
    endtask

    initial
    begin
        sb = new();
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            level[k]    = 1'b0;
            run_left[k] = 0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset thresholds: debounce, short press, tick wrap, long press, clears
        scan(32'd0, 0, 0, 0, 0);
        scan(32'd100, 1, 1, 0, 0);
        scan(32'd119, 0, 1, 0, 0);
        scan(32'd120, 1, 0, 0, 0);
        scan(32'd500, 0, 1, 0, 0);
        scan(32'd501, 0, 1, 1, 0);
        scan(32'hFFFF_FFF0, 1, 1, 0, 0);
        scan(32'h0000_0004, 1, 1, 0, 0);
        scan(32'd1004, 1, 1, 0, 0);
        // clear in the same word as a fresh event: the event survives
        scan(32'd1005, 1, 1, 0, 1);
        scan(32'd1006, 1, 0, 1, 0);
        scan(32'hFFFF_FFFF, 0, 0, 0, 0);
        scan(32'hFFFF_FFFF, 0, 0, 1, 1);

        // Zero thresholds: equal ticks confirm but do not go long
        retune(16'd0, 16'd0);
        scan(32'd7, 1, 0, 0, 0);
        scan(32'd7, 1, 0, 0, 0);
        scan(32'd7, 1, 0, 0, 0);
        scan(32'd8, 1, 1, 0, 0);
        scan(32'd8, 0, 0, 0, 0);

        // Largest thresholds, right on the boundaries
        retune(16'hFFFF, 16'hFFFF);
        scan(32'd0, 0, 1, 0, 0);
        scan(32'd65534, 0, 1, 0, 0);
        scan(32'd65535, 0, 1, 0, 0);
        scan(32'd131070, 0, 1, 0, 0);
        scan(32'd131071, 0, 1, 0, 0);
        scan(32'd131072, 0, 0, 1, 1);

        // Random part over several threshold settings
        scan_tick = 32'd131072;
        random_phase(16'd3, 16'd12, 62);
        random_phase(16'd0, 16'd0, 62);
        random_phase(16'hFFFF, 16'hFFFF, 62);
        random_phase(16'd0, 16'hFFFF, 62);
        random_phase(16'hFFFF, 16'd0, 62);
        random_phase(16'($urandom_range(0, 60)), 16'($urandom_range(0, 300)), 62);
        calm = 1'b1;
        random_phase(16'($urandom_range(1, 30)), 16'($urandom_range(1, 150)), 62);

        drain();
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("key_debounce_long_press_unit verification clean");
        else
            $display("key_debounce_long_press_unit verification failed");
        $finish;
    end

endmodule

/* files.f */
design/kdlp_pkg.sv
design/kdlp_lane.sv
design/kdlp_merge.sv
design/key_debounce_long_press_unit.sv
bench/testbench.sv
